[src/twms_pkg.sv]
// twms_pkg: shared types and constants for the tower window max-sum block
// no dependencies; used by twms_code, tower_window_max_sum and the testbench
`default_nettype none

package twms_pkg;

    // default grid geometry and window range
    localparam int DEF_ETA_BINS   = 128;
    localparam int DEF_PHI_BINS   = 256;
    localparam int DEF_MAX_WINDOW = 5;

    // fixed field widths
    localparam int TOWER_W    = 16;
    localparam int ETA_IDX_W  = 7;
    localparam int PHI_IDX_W  = 8;
    localparam int SIZE_W     = 3;
    localparam int RAW_OUT_W  = 21;
    localparam int TRIG_OUT_W = 14;

    // configuration port
    localparam int ETA_USED_W = 8;
    localparam int PHI_USED_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0]  REG_ETA_BINS_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_PHI_BINS_USED = 1'd1;
    localparam logic [ETA_USED_W-1:0] ETA_USED_RST      = 8'd128;
    localparam logic [PHI_USED_W-1:0] PHI_USED_RST      = 9'd256;

    // input operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // trigger code: round(e * 256 / 45000) as floor((e * 256 + 22500) * M >> 41)
    // M = ceil(2^41 / 45000) is exact for every operand below 2^25
    localparam int CODE_W      = 9;
    localparam int CODE_FRAC_W = 8;
    localparam int CODE_X_W    = 25;
    localparam int CODE_MUL_W  = 26;
    localparam int CODE_SHIFT  = 41;
    localparam logic [CODE_X_W-1:0]   CODE_RND = 25'd22500;
    localparam logic [CODE_MUL_W-1:0] CODE_MUL = 26'd48867184;

    // window ring index, wide enough for the largest window
    localparam int RING_W = 3;

    // tag that travels with each tower read through the code stage
    typedef struct packed {
        logic              valid;
        logic              live;
        logic [RING_W-1:0] ring;
    } twms_tag_t;

endpackage

`default_nettype wire

[src/twms_code.sv]
// twms_code: registered trigger-code stage, one tower per cycle
// depends on twms_pkg for widths, code constants and the tag type
`default_nettype none

module twms_code (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [twms_pkg::TOWER_W-1:0] energy_i,
    input  wire twms_pkg::twms_tag_t         tag_i,
    output twms_pkg::twms_tag_t              tag_o,
    output logic [twms_pkg::TOWER_W-1:0]     raw_o,
    output logic [twms_pkg::CODE_W-1:0]      code_o
);

    localparam int PROD_W = twms_pkg::CODE_X_W + twms_pkg::CODE_MUL_W;

    logic [twms_pkg::TOWER_W-1:0]  energy_live;
    logic [twms_pkg::CODE_X_W-1:0] code_x;
    logic [PROD_W-1:0]             code_prod;

    // towers past the eta edge count as zero
    assign energy_live = tag_i.live ? energy_i : '0;
    assign code_x      = twms_pkg::CODE_X_W'({energy_live, {twms_pkg::CODE_FRAC_W{1'b0}}})
                       + twms_pkg::CODE_RND;
    assign code_prod   = PROD_W'(code_x) * PROD_W'(twms_pkg::CODE_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_o <= '0;
        end else begin
            tag_o <= tag_i;
        end
    end

    always_ff @(posedge aclk) begin
        raw_o  <= energy_live;
        code_o <= code_prod[twms_pkg::CODE_SHIFT +: twms_pkg::CODE_W];
    end

endmodule

`default_nettype wire

[src/tower_window_max_sum.sv]
// tower_window_max_sum: tower grid store and sliding-window maximum finder
// depends on twms_pkg and twms_code
//
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_op, s_eta_index, s_phi_index, s_tower_energy
//  m_       out  m_valid / m_ready  m_window_size, m_max_energy_sum,
//                                   m_max_trigger_sum, m_max_slide2_sum, m_last
//  cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// the grid takes one tower write beat per cycle while idle
// an evaluate beat scans every anchor of the used area, reading one tower per cycle
// in ST_SCAN through the single grid read port, with a per-side fold after each anchor
// then MAX_WINDOW result beats, one per cycle while m_ready is high
// after reset and after the last result beat a clearing pass writes zero to the
// whole grid with s_ready low; cfg writes are taken always
// m_ready low simply holds the current result beat
`default_nettype none

module tower_window_max_sum #(
    parameter int ETA_BINS   = twms_pkg::DEF_ETA_BINS,
    parameter int PHI_BINS   = twms_pkg::DEF_PHI_BINS,
    parameter int MAX_WINDOW = twms_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [twms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [twms_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input beats
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [twms_pkg::ETA_IDX_W-1:0]    s_eta_index,
    input  wire logic [twms_pkg::PHI_IDX_W-1:0]    s_phi_index,
    input  wire logic [twms_pkg::TOWER_W-1:0]      s_tower_energy,
    // result beats
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [twms_pkg::SIZE_W-1:0]            m_window_size,
    output logic [twms_pkg::RAW_OUT_W-1:0]         m_max_energy_sum,
    output logic [twms_pkg::TRIG_OUT_W-1:0]        m_max_trigger_sum,
    output logic [twms_pkg::TRIG_OUT_W-1:0]        m_max_slide2_sum,
    output logic                                   m_last
);

    // geometry derived from the parameters
    localparam int EW     = (ETA_BINS > 1) ? $clog2(ETA_BINS) : 1;
    localparam int PW     = $clog2(PHI_BINS);
    localparam int NEW    = $clog2(ETA_BINS + 1);
    localparam int NPW    = $clog2(PHI_BINS + 1);
    localparam int ETW    = $clog2(ETA_BINS + MAX_WINDOW);
    localparam int SW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH  = ETA_BINS * PHI_BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SUM_W  = twms_pkg::TOWER_W + $clog2(MAX_WINDOW * MAX_WINDOW);
    localparam int CSUM_W = twms_pkg::CODE_W + $clog2(MAX_WINDOW * MAX_WINDOW);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // zero the grid
    localparam logic [2:0] ST_IDLE  = 3'd1;  // take writes and evaluate beats
    localparam logic [2:0] ST_SCAN  = 3'd2;  // read the towers of one anchor
    localparam logic [2:0] ST_DRAIN = 3'd3;  // let the read pipeline empty
    localparam logic [2:0] ST_FOLD  = 3'd4;  // ring sums into window sums and maxima
    localparam logic [2:0] ST_SEND  = 3'd5;  // one result beat per window side

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [twms_pkg::ETA_USED_W-1:0] eta_used_reg;
    logic [twms_pkg::PHI_USED_W-1:0] phi_used_reg;

    // grid store
    logic [twms_pkg::TOWER_W-1:0] tower_mem [DEPTH];
    logic [twms_pkg::TOWER_W-1:0] rd_data_reg;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [twms_pkg::TOWER_W-1:0] mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [AW-1:0]                clr_addr_reg;

    // evaluation walk
    logic [NEW-1:0] n_eta_reg, n_eta_sat;
    logic [NPW-1:0] n_phi_reg, n_phi_sat;
    logic [EW-1:0]  a_eta_reg;
    logic [PW-1:0]  a_phi_reg;
    logic [ETW-1:0] et_reg;
    logic [PW-1:0]  ph_reg, ph_inc;
    logic [SW-1:0]  de_reg, dp_reg, side_reg, ring_idx;
    logic           de_last, dp_last, side_last, anchor_last, eta_wrap;
    logic           et_live, eval_empty, s_accept, write_hit;
    logic [AW-1:0]  scan_addr;

    // read pipeline tags
    twms_pkg::twms_tag_t          tag_a, tag_b_reg, tag_c;
    logic [twms_pkg::TOWER_W-1:0] raw_c;
    logic [twms_pkg::CODE_W-1:0]  code_c;

    // per-ring partial sums, running window sums and maxima
    logic [SUM_W-1:0]  ring_raw_reg  [MAX_WINDOW];
    logic [CSUM_W-1:0] ring_code_reg [MAX_WINDOW];
    logic [SUM_W-1:0]  run_raw_reg;
    logic [CSUM_W-1:0] run_code_reg;
    logic [SUM_W-1:0]  max_raw_reg   [MAX_WINDOW];
    logic [CSUM_W-1:0] max_code_reg  [MAX_WINDOW];
    logic [CSUM_W-1:0] max_even_reg  [2];
    logic [SUM_W-1:0]  fold_raw;
    logic [CSUM_W-1:0] fold_code;
    logic              even_anchor;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_SEND);
    assign s_accept = s_valid && s_ready;

    // used area, saturated to the store geometry
    assign n_eta_sat  = (32'(eta_used_reg) > ETA_BINS) ? NEW'(ETA_BINS) : NEW'(eta_used_reg);
    assign n_phi_sat  = (32'(phi_used_reg) > PHI_BINS) ? NPW'(PHI_BINS) : NPW'(phi_used_reg);
    assign eval_empty = (n_eta_sat == '0) || (n_phi_sat == '0);

    // writes outside the store are dropped
    assign write_hit = (32'(s_eta_index) < ETA_BINS) && (32'(s_phi_index) < PHI_BINS);

    assign de_last     = (de_reg == SW'(MAX_WINDOW - 1));
    assign dp_last     = (dp_reg == SW'(MAX_WINDOW - 1));
    assign side_last   = (side_reg == SW'(MAX_WINDOW - 1));
    assign eta_wrap    = (32'(a_eta_reg) + 1 == 32'(n_eta_reg));
    assign anchor_last = eta_wrap && (32'(a_phi_reg) + 1 == 32'(n_phi_reg));

    // phi step with wrap at the used column count
    assign ph_inc = (32'(ph_reg) + 1 == 32'(n_phi_reg)) ? '0 : ph_reg + 1'b1;

    // rows at or past the used eta count read as zero
    assign et_live   = (32'(et_reg) < 32'(n_eta_reg));
    assign scan_addr = et_live ? AW'(32'(et_reg) * PHI_BINS + 32'(ph_reg)) : '0;
    assign ring_idx  = (de_reg > dp_reg) ? de_reg : dp_reg;

    assign tag_a.valid = (state_reg == ST_SCAN);
    assign tag_a.live  = et_live;
    assign tag_a.ring  = twms_pkg::RING_W'(ring_idx);

    // store port control: clearing pass or a tower write beat
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (s_accept && s_op == twms_pkg::OP_WRITE && write_hit) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(32'(s_eta_index) * PHI_BINS + 32'(s_phi_index));
            mem_wdata = s_tower_energy;
        end
    end
    assign mem_raddr = scan_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tower_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tower_mem[mem_raddr];
    end

    // trigger code of each tower read
    twms_code u_code (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .energy_i (rd_data_reg),
        .tag_i    (tag_b_reg),
        .tag_o    (tag_c),
        .raw_o    (raw_c),
        .code_o   (code_c)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept && s_op == twms_pkg::OP_EVAL) begin
                    state_next = eval_empty ? ST_SEND : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (de_last && dp_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!tag_b_reg.valid && !tag_c.valid) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                if (side_last) state_next = anchor_last ? ST_SEND : ST_SCAN;
            end
            ST_SEND: begin
                if (m_ready && side_last) state_next = ST_CLEAR;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            tag_b_reg    <= '0;
            eta_used_reg <= twms_pkg::ETA_USED_RST;
            phi_used_reg <= twms_pkg::PHI_USED_RST;
        end else begin
            state_reg <= state_next;
            tag_b_reg <= tag_a;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= (clr_addr_reg == AW'(DEPTH - 1)) ? '0 : clr_addr_reg + 1'b1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    twms_pkg::REG_ETA_BINS_USED: eta_used_reg <= twms_pkg::ETA_USED_W'(cfg_wdata);
                    twms_pkg::REG_PHI_BINS_USED: phi_used_reg <= twms_pkg::PHI_USED_W'(cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // fold: window of side s+1 is the sum of rings 0..s
    assign fold_raw    = ((side_reg == '0) ? '0 : run_raw_reg) + ring_raw_reg[side_reg];
    assign fold_code   = ((side_reg == '0) ? '0 : run_code_reg) + ring_code_reg[side_reg];
    assign even_anchor = !a_eta_reg[0] && !a_phi_reg[0];

    // walk counters, ring sums and maxima
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_op == twms_pkg::OP_EVAL) begin
                    n_eta_reg <= n_eta_sat;
                    n_phi_reg <= n_phi_sat;
                    a_eta_reg <= '0;
                    a_phi_reg <= '0;
                    et_reg    <= '0;
                    ph_reg    <= '0;
                    de_reg    <= '0;
                    dp_reg    <= '0;
                    side_reg  <= '0;
                    for (int i = 0; i < MAX_WINDOW; i++) begin
                        ring_raw_reg[i]  <= '0;
                        ring_code_reg[i] <= '0;
                        max_raw_reg[i]   <= '0;
                        max_code_reg[i]  <= '0;
                    end
                    max_even_reg[0] <= '0;
                    max_even_reg[1] <= '0;
                end
            end
            ST_SCAN: begin
                // column by column: eta inner, phi outer
                if (de_last) begin
                    de_reg <= '0;
                    et_reg <= ETW'(a_eta_reg);
                    if (!dp_last) begin
                        dp_reg <= dp_reg + 1'b1;
                        ph_reg <= ph_inc;
                    end
                end else begin
                    de_reg <= de_reg + 1'b1;
                    et_reg <= et_reg + 1'b1;
                end
            end
            ST_FOLD: begin
                ring_raw_reg[side_reg]  <= '0;
                ring_code_reg[side_reg] <= '0;
                run_raw_reg             <= fold_raw;
                run_code_reg            <= fold_code;
                if (fold_raw > max_raw_reg[side_reg]) max_raw_reg[side_reg] <= fold_raw;
                if (fold_code > max_code_reg[side_reg]) max_code_reg[side_reg] <= fold_code;
                // sides two and four also track even-anchored windows
                if (even_anchor && 32'(side_reg) == 1 && fold_code > max_even_reg[0]) begin
                    max_even_reg[0] <= fold_code;
                end
                if (even_anchor && 32'(side_reg) == 3 && fold_code > max_even_reg[1]) begin
                    max_even_reg[1] <= fold_code;
                end
                if (side_last) begin
                    side_reg <= '0;
                    de_reg   <= '0;
                    dp_reg   <= '0;
                    if (eta_wrap) begin
                        a_eta_reg <= '0;
                        a_phi_reg <= a_phi_reg + 1'b1;
                        et_reg    <= '0;
                        ph_reg    <= a_phi_reg + 1'b1;
                    end else begin
                        a_eta_reg <= a_eta_reg + 1'b1;
                        et_reg    <= ETW'(a_eta_reg) + 1'b1;
                        ph_reg    <= a_phi_reg;
                    end
                end else begin
                    side_reg <= side_reg + 1'b1;
                end
            end
            ST_SEND: begin
                if (m_ready) side_reg <= side_last ? '0 : side_reg + 1'b1;
            end
            default: ;
        endcase
        // accumulate each coded tower into its ring
        if (tag_c.valid) begin
            ring_raw_reg[tag_c.ring[SW-1:0]]  <= ring_raw_reg[tag_c.ring[SW-1:0]]
                                               + SUM_W'(raw_c);
            ring_code_reg[tag_c.ring[SW-1:0]] <= ring_code_reg[tag_c.ring[SW-1:0]]
                                               + CSUM_W'(code_c);
        end
    end

    // result beat for the current side
    assign m_window_size     = twms_pkg::SIZE_W'(32'(side_reg) + 1);
    assign m_max_energy_sum  = twms_pkg::RAW_OUT_W'(32'(max_raw_reg[side_reg]));
    assign m_max_trigger_sum = twms_pkg::TRIG_OUT_W'(32'(max_code_reg[side_reg]));
    assign m_max_slide2_sum  = (32'(side_reg) == 1) ?
                                   twms_pkg::TRIG_OUT_W'(32'(max_even_reg[0])) :
                               (32'(side_reg) == 3) ?
                                   twms_pkg::TRIG_OUT_W'(32'(max_even_reg[1])) : '0;
    assign m_last            = side_last;

`ifndef NO_ASSERTIONS
    // input and result sides never open together
    a_ready_send_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready and m_valid high together");

    // fold only reads rings after every tower read has landed
    a_fold_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |-> (!tag_b_reg.valid && !tag_c.valid))
        else $error("ring accumulate pending during fold");

    // the last result beat starts a clearing pass from the first entry
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (state_reg == ST_CLEAR && clr_addr_reg == '0))
        else $error("grid clear did not follow the last result beat");

    // an evaluate beat closes the input side
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == twms_pkg::OP_EVAL) |=> !s_ready)
        else $error("input taken right after an evaluate beat");
`endif

endmodule

`default_nettype wire

[dv/tower_window_max_sum_test.sv]
// self-checking testbench for tower_window_max_sum: tower writes and evaluates in,
// per-side window maxima out, checked against an in-bench grid predictor
// depends on twms_pkg and the tower_window_max_sum rtl
`timescale 1ns / 1ps

module tower_window_max_sum_test;

    // trigger code step: round(e * 256 / 45000), e in MeV
    localparam int unsigned STEP_NUM     = 256;
    localparam int unsigned STEP_DEN     = 45000;
    localparam int unsigned RUN_LIMIT_NS = 400_000_000;
    localparam int          PHASE_ITEMS  = 30;

    typedef struct packed {
        logic                           op;
        logic [twms_pkg::ETA_IDX_W-1:0] eta;
        logic [twms_pkg::PHI_IDX_W-1:0] phi;
        logic [twms_pkg::TOWER_W-1:0]   energy;
    } tower_beat_t;

    typedef struct packed {
        logic [twms_pkg::SIZE_W-1:0]     size;
        logic [twms_pkg::RAW_OUT_W-1:0]  energy_sum;
        logic [twms_pkg::TRIG_OUT_W-1:0] trigger_sum;
        logic [twms_pkg::TRIG_OUT_W-1:0] slide2_sum;
        logic                            last;
    } window_max_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // block inputs, all known from time zero
    logic                            cfg_we         = 1'b0;
    logic [twms_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [twms_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                            s_valid        = 1'b0;
    logic                            s_op           = twms_pkg::OP_WRITE;
    logic [twms_pkg::ETA_IDX_W-1:0]  s_eta_index    = '0;
    logic [twms_pkg::PHI_IDX_W-1:0]  s_phi_index    = '0;
    logic [twms_pkg::TOWER_W-1:0]    s_tower_energy = '0;
    logic                            m_ready        = 1'b0;

    // block outputs
    logic                            s_ready;
    logic                            m_valid;
    logic [twms_pkg::SIZE_W-1:0]     m_window_size;
    logic [twms_pkg::RAW_OUT_W-1:0]  m_max_energy_sum;
    logic [twms_pkg::TRIG_OUT_W-1:0] m_max_trigger_sum;
    logic [twms_pkg::TRIG_OUT_W-1:0] m_max_slide2_sum;
    logic                            m_last;

    // predictor state: grid copy and used geometry
    logic [twms_pkg::TOWER_W-1:0] tower_grid [0:twms_pkg::DEF_ETA_BINS-1]
                                             [0:twms_pkg::DEF_PHI_BINS-1];
    int unsigned grid_eta_rows = 32'(twms_pkg::ETA_USED_RST);
    int unsigned grid_phi_cols = 32'(twms_pkg::PHI_USED_RST);

    tower_beat_t tower_beats_q [$];
    window_max_t expected_maxima [$];
    window_max_t want_max;
    tower_beat_t next_beat;

    logic s_fire = 1'b0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   mismatch_count     = 0;
    int   writes_taken       = 0;
    int   evals_taken        = 0;
    int   results_seen       = 0;

    tower_window_max_sum DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_eta_index       (s_eta_index),
        .s_phi_index       (s_phi_index),
        .s_tower_energy    (s_tower_energy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_window_size     (m_window_size),
        .m_max_energy_sum  (m_max_energy_sum),
        .m_max_trigger_sum (m_max_trigger_sum),
        .m_max_slide2_sum  (m_max_slide2_sum),
        .m_last            (m_last)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    task automatic clear_tower_grid();
        for (int et = 0; et < twms_pkg::DEF_ETA_BINS; et++)
            for (int ph = 0; ph < twms_pkg::DEF_PHI_BINS; ph++)
                tower_grid[et][ph] = '0;
    endtask

    // sweep every anchor and side over the used area, queue one beat per side,
    // then clear the grid as the block does after sending
    task automatic predict_window_maxima();
        int unsigned n_eta, n_phi, raw, code, e, ph, et;
        int unsigned best_raw  [1:twms_pkg::DEF_MAX_WINDOW];
        int unsigned best_code [1:twms_pkg::DEF_MAX_WINDOW];
        int unsigned best_even [0:1];
        window_max_t res;
        n_eta = (grid_eta_rows > twms_pkg::DEF_ETA_BINS) ? twms_pkg::DEF_ETA_BINS
                                                          : grid_eta_rows;
        n_phi = (grid_phi_cols > twms_pkg::DEF_PHI_BINS) ? twms_pkg::DEF_PHI_BINS
                                                          : grid_phi_cols;
        for (int side = 1; side <= twms_pkg::DEF_MAX_WINDOW; side++) begin
            best_raw[side]  = 0;
            best_code[side] = 0;
        end
        best_even[0] = 0;
        best_even[1] = 0;
        // zero rows or columns leave every maximum at zero
        if (n_eta != 0 && n_phi != 0) begin
            for (int unsigned a_phi = 0; a_phi < n_phi; a_phi++) begin
                for (int unsigned a_eta = 0; a_eta < n_eta; a_eta++) begin
                    for (int side = 1; side <= twms_pkg::DEF_MAX_WINDOW; side++) begin
                        raw  = 0;
                        code = 0;
                        for (int dp = 0; dp < side; dp++) begin
                            // phi wraps at the used column count, even inside one window
                            ph = (a_phi + dp) % n_phi;
                            for (int de = 0; de < side; de++) begin
                                et = a_eta + de;
                                // rows past the eta edge add nothing
                                if (et < n_eta) begin
                                    e    = 32'(tower_grid[et][ph]);
                                    raw  += e;
                                    code += (e * STEP_NUM + STEP_DEN / 2) / STEP_DEN;
                                end
                            end
                        end
                        if (raw > best_raw[side])
                            best_raw[side] = raw;
                        if (code > best_code[side])
                            best_code[side] = code;
                        // even-anchored windows for sides 2 and 4
                        if ((side == 2 || side == 4) && a_phi[0] == 1'b0 &&
                            a_eta[0] == 1'b0) begin
                            if (code > best_even[side / 4])
                                best_even[side / 4] = code;
                        end
                    end
                end
            end
        end
        for (int side = 1; side <= twms_pkg::DEF_MAX_WINDOW; side++) begin
            res.size        = twms_pkg::SIZE_W'(side);
            res.energy_sum  = twms_pkg::RAW_OUT_W'(best_raw[side]);
            res.trigger_sum = twms_pkg::TRIG_OUT_W'(best_code[side]);
            res.slide2_sum  = twms_pkg::TRIG_OUT_W'((side == 2) ? best_even[0] :
                                                    (side == 4) ? best_even[1] : 0);
            res.last        = (side == twms_pkg::DEF_MAX_WINDOW);
            expected_maxima.push_back(res);
        end
        clear_tower_grid();
    endtask

    // input side: note each accepted beat and feed it to the predictor
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            if (s_op == twms_pkg::OP_WRITE) begin
                tower_grid[s_eta_index][s_phi_index] = s_tower_energy;
                writes_taken++;
            end else begin
                predict_window_maxima();
                evals_taken++;
            end
        end
    end

    // driver: next beat at the falling edge, payload held until accepted
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (tower_beats_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_beat = tower_beats_q.pop_front();
                s_valid        <= 1'b1;
                s_op           <= next_beat.op;
                s_eta_index    <= next_beat.eta;
                s_phi_index    <= next_beat.phi;
                s_tower_energy <= next_beat.energy;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // monitor: each result beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_maxima.size() == 0) begin
                report_mismatch("result beat with nothing expected, size", 0,
                                32'(m_window_size));
            end else begin
                want_max = expected_maxima.pop_front();
                if (m_window_size !== want_max.size)
                    report_mismatch("window_size", 32'(want_max.size), 32'(m_window_size));
                if (m_max_energy_sum !== want_max.energy_sum)
                    report_mismatch("max_energy_sum", 32'(want_max.energy_sum),
                                    32'(m_max_energy_sum));
                if (m_max_trigger_sum !== want_max.trigger_sum)
                    report_mismatch("max_trigger_sum", 32'(want_max.trigger_sum),
                                    32'(m_max_trigger_sum));
                if (m_max_slide2_sum !== want_max.slide2_sum)
                    report_mismatch("max_slide2_sum", 32'(want_max.slide2_sum),
                                    32'(m_max_slide2_sum));
                if (m_last !== want_max.last)
                    report_mismatch("last", 32'(want_max.last), 32'(m_last));
            end
        end
    end

    task automatic push_write(input logic [twms_pkg::ETA_IDX_W-1:0] eta,
                              input logic [twms_pkg::PHI_IDX_W-1:0] phi,
                              input logic [twms_pkg::TOWER_W-1:0]   energy);
        tower_beat_t b;
        b.op     = twms_pkg::OP_WRITE;
        b.eta    = eta;
        b.phi    = phi;
        b.energy = energy;
        tower_beats_q.push_back(b);
    endtask

    // evaluate beat with junk in the unused fields
    task automatic push_eval();
        tower_beat_t b;
        b.op     = twms_pkg::OP_EVAL;
        b.eta    = twms_pkg::ETA_IDX_W'($urandom);
        b.phi    = twms_pkg::PHI_IDX_W'($urandom);
        b.energy = twms_pkg::TOWER_W'($urandom);
        tower_beats_q.push_back(b);
    endtask

    // wait for every queued beat to go and every result to come back
    task automatic drain();
        while (tower_beats_q.size() != 0 || s_valid || expected_maxima.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [twms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [twms_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == twms_pkg::REG_ETA_BINS_USED)
            grid_eta_rows = 32'(data[twms_pkg::ETA_USED_W-1:0]);
        else
            grid_phi_cols = 32'(data[twms_pkg::PHI_USED_W-1:0]);
    endtask

    // new geometry only once the block is idle, past its clearing pass
    task automatic reprogram(input logic [twms_pkg::CFG_DATA_W-1:0] eta_val,
                             input logic [twms_pkg::CFG_DATA_W-1:0] phi_val);
        drain();
        repeat (8) @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        write_reg(twms_pkg::REG_ETA_BINS_USED, eta_val);
        write_reg(twms_pkg::REG_PHI_BINS_USED, phi_val);
    endtask

    // random bursts: mostly writes inside the used area, then an evaluate
    task automatic run_random_phase(input int idle_p, input int stall_p);
        int items, n, eta_lim, phi_lim, eta, phi, energy;
        items = 0;
        reprogram(twms_pkg::CFG_DATA_W'($urandom_range(1, 8)),
                  twms_pkg::CFG_DATA_W'($urandom_range(1, 12)));
        sender_idle_pct    = idle_p;
        receiver_stall_pct = stall_p;
        eta_lim = grid_eta_rows;
        phi_lim = grid_phi_cols;
        while (items < PHASE_ITEMS) begin
            n = $urandom_range(6, 16);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < 85) begin
                    eta = $urandom_range(0, eta_lim - 1);
                    phi = $urandom_range(0, phi_lim - 1);
                end else begin
                    // stray write anywhere in the store
                    eta = $urandom_range(0, twms_pkg::DEF_ETA_BINS - 1);
                    phi = $urandom_range(0, twms_pkg::DEF_PHI_BINS - 1);
                end
                case ($urandom_range(0, 9))
                    0:       energy = 0;
                    1:       energy = 'hFFFF;
                    2:       energy = $urandom_range(80, 100);
                    default: energy = $urandom_range(0, 'hFFFF);
                endcase
                push_write(twms_pkg::ETA_IDX_W'(eta), twms_pkg::PHI_IDX_W'(phi),
                           twms_pkg::TOWER_W'(energy));
            end
            push_eval();
            items += n + 1;
            // back-to-back evaluate sees a freshly cleared grid
            if ($urandom_range(0, 9) == 0) begin
                push_eval();
                items++;
            end
        end
    endtask

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        clear_tower_grid();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: small grid, extremes of energy and index
        reprogram(6, 5);
        push_write(0, 0, 16'hFFFF);
        push_write(1, 1, 16'hFFFF);
        push_write(5, 4, 16'hFFFF);      // last used row and column
        push_write(2, 3, 87);            // just below one code step
        push_write(3, 3, 88);            // just above
        push_write(2, 3, 1);             // overwrite
        push_write(127, 255, 16'h8000);  // outside the used area, stored only
        push_write(0, 4, 40000);         // window wraps from column 4 to 0
        push_eval();
        push_eval();                     // empty grid

        // zero rows
        reprogram(0, 5);
        push_write(0, 0, 16'hFFFF);
        push_eval();

        // zero columns
        reprogram(4, 0);
        push_write(1, 0, 16'hFFFF);
        push_eval();

        // full eta range, single column: eta edge and narrow wrap
        reprogram(128, 1);
        push_write(127, 0, 16'hFFFF);
        push_write(126, 0, 16'hFFFF);
        push_write(0, 0, 12345);
        push_eval();

        // eta register above the grid size saturates; bit 8 of the data dropped
        reprogram(9'h1FF, 2);
        push_write(127, 1, 16'hFFFF);
        push_write(0, 0, 1000);
        push_eval();

        // full phi range, single row: wrap across column 255 to 0
        reprogram(1, 256);
        push_write(0, 255, 16'hFFFF);
        push_write(0, 0, 16'hFFFF);
        push_write(0, 1, 30000);
        push_eval();

        // phi register above the grid size saturates
        reprogram(1, 9'h1FF);
        push_write(0, 255, 50000);
        push_write(0, 128, 16'hFFFF);
        push_eval();

        // random phases with different idling
        run_random_phase(0, 0);
        run_random_phase(51, 0);
        run_random_phase(0, 51);
        run_random_phase(8, 8);

        drain();
        repeat (200) @(posedge aclk);

        $display("covered %0d tower writes and %0d evaluates over several grid shapes,",
                 writes_taken, evals_taken);
        $display("%0d result beats checked under sender gaps and receiver stalls",
                 results_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[tower_window_max_sum.f]
src/twms_pkg.sv
src/twms_code.sv
src/tower_window_max_sum.sv
dv/tower_window_max_sum_test.sv
